@@ design/uart_register_flag_model_assert.svh @@
// assertion macros for the usart flag block
// expects clk and arst_n in the scope where a macro is used
`ifndef UART_REGISTER_FLAG_MODEL_ASSERT_SVH
`define UART_REGISTER_FLAG_MODEL_ASSERT_SVH

// same-cycle implication, reset masked
`define URFM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define URFM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/urfm_pkg.sv @@
// shared types and codes for the usart register and flag block
// no dependencies
`timescale 1ns / 1ps

package urfm_pkg;

	typedef enum logic [2:0] {
		OP_WRITE_TX   = 3'd0,
		OP_READ_RX    = 3'd1,
		OP_CLEAR_FLAG = 3'd2,
		OP_READ_FLAG  = 3'd3,
		OP_BREAK_REQ  = 3'd4,
		OP_LINE_BYTE  = 3'd5,
		OP_LINE_BREAK = 3'd6,
		OP_TICK       = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		SEL_TC   = 2'd0,
		SEL_LBD  = 2'd1,
		SEL_RXNE = 2'd2,
		SEL_NONE = 2'd3
	} flag_sel_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DATA  = 2'd1,
		PH_BREAK = 2'd2
	} phase_t;

	localparam int unsigned CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_TXE_IEN  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TC_IEN   = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RXNE_IEN = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LBD_IEN  = 8'd3;

	typedef struct packed {
		logic       txe;
		logic       tc;
		logic       rxne;
		logic       lbd;
	} irq_en_t;

	typedef struct packed {
		logic [7:0] tx_holding;
		logic [7:0] tx_shift_copy;
		logic [7:0] rx_holding;
		logic       txe;
		logic       tc;
		logic       rxne;
		logic       lbd;
		phase_t     tx_phase;
		logic       break_pending;
	} state_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       flag_value;
		logic       irq;
		logic       line_tx_valid;
		logic       line_tx_is_break;
		logic [7:0] line_tx_byte;
	} result_t;

endpackage

@@ design/uart_register_flag_model.sv @@
// top level of the usart register and flag block: handshake, state and config
// depends on urfm_pkg, urfm_engine and uart_register_flag_model_assert.svh
`timescale 1ns / 1ps

//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  in       | in_valid / in_stall    | operation, data_byte, flag_select
//  out      | out_valid / out_stall  | read_byte, flag_value, irq, line_tx_valid,
//           |                        | line_tx_is_break, line_tx_byte
//  cfg      | cfg_write              | cfg_index, cfg_data
//
// one transaction a cycle sustained while out_stall is low; an item passes from input to result
// through the input register, then the flag logic into the result register
// the state registers are updated as the item leaves the input register
// reset clears the flags, bytes, phase and enables; txe comes up set
// out_stall holds the result register, and the input stage stalls only when
// it is full and its item cannot move into the held result register

`include "uart_register_flag_model_assert.svh"

module uart_register_flag_model (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       operation,
	input  logic [7:0]                       data_byte,
	input  logic [1:0]                       flag_select,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       read_byte,
	output logic                             flag_value,
	output logic                             irq,
	output logic                             line_tx_valid,
	output logic                             line_tx_is_break,
	output logic [7:0]                       line_tx_byte,
	input  logic                             cfg_write,
	input  logic [urfm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                             cfg_data
);

	logic                valid_s1;
	urfm_pkg::op_t       op_s1;
	logic [7:0]          data_s1;
	urfm_pkg::flag_sel_t sel_s1;

	urfm_pkg::state_t    state_q;
	urfm_pkg::state_t    state_nxt;
	urfm_pkg::irq_en_t   irq_en_q;
	urfm_pkg::result_t   res_nxt;
	urfm_pkg::result_t   res_q;
	logic                out_valid_q;

	logic advance;
	logic take_in;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1   <= urfm_pkg::op_t'(operation);
			data_s1 <= data_byte;
			sel_s1  <= urfm_pkg::flag_sel_t'(flag_select);
		end
	end

	urfm_engine u_engine (
		.op     (op_s1),
		.data   (data_s1),
		.sel    (sel_s1),
		.irq_en (irq_en_q),
		.cur    (state_q),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				tx_holding:    8'd0,
				tx_shift_copy: 8'd0,
				rx_holding:    8'd0,
				txe:           1'b1,
				tc:            1'b0,
				rxne:          1'b0,
				lbd:           1'b0,
				tx_phase:      urfm_pkg::PH_IDLE,
				break_pending: 1'b0
			};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				urfm_pkg::CFG_TXE_IEN:  irq_en_q.txe  <= cfg_data;
				urfm_pkg::CFG_TC_IEN:   irq_en_q.tc   <= cfg_data;
				urfm_pkg::CFG_RXNE_IEN: irq_en_q.rxne <= cfg_data;
				urfm_pkg::CFG_LBD_IEN:  irq_en_q.lbd  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_byte        = res_q.read_byte;
	assign flag_value       = res_q.flag_value;
	assign irq              = res_q.irq;
	assign line_tx_valid    = res_q.line_tx_valid;
	assign line_tx_is_break = res_q.line_tx_is_break;
	assign line_tx_byte     = res_q.line_tx_byte;

	`URFM_ASSERT_NXT(a_result_follows, advance, out_valid_q,
		"item left input stage without result")
	`URFM_ASSERT_NXT(a_tick_sets_txe, advance && op_s1 == urfm_pkg::OP_TICK, state_q.txe,
		"txe clear after tick")
	`URFM_ASSERT_IMP(a_break_shape, out_valid_q && res_q.line_tx_is_break,
		res_q.line_tx_valid && res_q.line_tx_byte == 8'd0, "break result malformed")

endmodule

@@ design/urfm_engine.sv @@
// next-state and result logic for one operation of the usart block
// depends on urfm_pkg
`timescale 1ns / 1ps

module urfm_engine (
	input  urfm_pkg::op_t       op,
	input  logic [7:0]          data,
	input  urfm_pkg::flag_sel_t sel,
	input  urfm_pkg::irq_en_t   irq_en,
	input  urfm_pkg::state_t    cur,
	output urfm_pkg::state_t    nxt,
	output urfm_pkg::result_t   res
);

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (op)
			urfm_pkg::OP_WRITE_TX: begin
				nxt.tx_holding = data;
				nxt.txe        = 1'b0;
			end
			urfm_pkg::OP_READ_RX: begin
				res.read_byte = cur.rx_holding;
				nxt.rxne      = 1'b0;
			end
			urfm_pkg::OP_CLEAR_FLAG: begin
				case (sel)
					urfm_pkg::SEL_TC:  nxt.tc  = 1'b0;
					urfm_pkg::SEL_LBD: nxt.lbd = 1'b0;
					default: ;
				endcase
			end
			urfm_pkg::OP_READ_FLAG: begin
				case (sel)
					urfm_pkg::SEL_TC:   res.flag_value = cur.tc;
					urfm_pkg::SEL_LBD:  res.flag_value = cur.lbd;
					urfm_pkg::SEL_RXNE: res.flag_value = cur.rxne;
					default:            res.flag_value = 1'b0;
				endcase
			end
			urfm_pkg::OP_BREAK_REQ: begin
				nxt.break_pending = 1'b1;
			end
			urfm_pkg::OP_LINE_BYTE: begin
				nxt.rx_holding = data;
				nxt.rxne       = 1'b1;
			end
			urfm_pkg::OP_LINE_BREAK: begin
				nxt.lbd = 1'b1;
			end
			urfm_pkg::OP_TICK: begin
				// finish the transfer in flight, only while tc is clear
				if (cur.tx_phase != urfm_pkg::PH_IDLE && !cur.tc) begin
					nxt.tc = 1'b1;
					case (cur.tx_phase)
						urfm_pkg::PH_DATA: begin
							res.line_tx_valid = 1'b1;
							res.line_tx_byte  = cur.tx_shift_copy;
						end
						urfm_pkg::PH_BREAK: begin
							res.line_tx_valid    = 1'b1;
							res.line_tx_is_break = 1'b1;
						end
						default: ;
					endcase
					nxt.tx_phase = urfm_pkg::PH_IDLE;
				end
				if (cur.break_pending) begin
					nxt.break_pending = 1'b0;
					nxt.tc            = 1'b0;
					nxt.tx_phase      = urfm_pkg::PH_BREAK;
				end
				// a data load overrides a break started in the same tick
				if (!cur.txe) begin
					nxt.tx_shift_copy = cur.tx_holding;
					nxt.tc            = 1'b0;
					nxt.txe           = 1'b1;
					nxt.tx_phase      = urfm_pkg::PH_DATA;
				end
				res.irq = (nxt.txe & irq_en.txe) | (nxt.lbd & irq_en.lbd) |
					(nxt.rxne & irq_en.rxne) | (nxt.tc & irq_en.tc);
			end
			default: ;
		endcase
	end

endmodule

@@ bench/urfm_flag_checker.sv @@
// checker for the usart register and flag block: tracks the enables and flag state,
// predicts one result per accepted operation and compares the results in order
// depends on urfm_pkg
`timescale 1ns / 1ps

module urfm_flag_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [2:0]                       operation,
	input  logic [7:0]                       data_byte,
	input  logic [1:0]                       flag_select,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [7:0]                       read_byte,
	input  logic                             flag_value,
	input  logic                             irq,
	input  logic                             line_tx_valid,
	input  logic                             line_tx_is_break,
	input  logic [7:0]                       line_tx_byte,
	input  logic                             cfg_write,
	input  logic [urfm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                             cfg_data,
	output int                               mismatches,
	output int                               outstanding
);

	urfm_pkg::irq_en_t ien;
	logic [7:0]        tx_byte, shift_byte, rx_byte;
	logic              txe, tc, rxne, lbd, break_req;
	urfm_pkg::phase_t  phase;
	urfm_pkg::result_t expected_q[$];
	urfm_pkg::result_t want;

	function automatic urfm_pkg::result_t predict_usart(urfm_pkg::op_t op,
		logic [7:0] data, urfm_pkg::flag_sel_t sel);
		urfm_pkg::result_t r;
		r = '0;
		case (op)
			urfm_pkg::OP_WRITE_TX: begin
				tx_byte = data;
				txe = 1'b0;
			end
			urfm_pkg::OP_READ_RX: begin
				r.read_byte = rx_byte;
				rxne = 1'b0;
			end
			urfm_pkg::OP_CLEAR_FLAG: begin
				if (sel == urfm_pkg::SEL_TC) tc = 1'b0;
				else if (sel == urfm_pkg::SEL_LBD) lbd = 1'b0;
			end
			urfm_pkg::OP_READ_FLAG: begin
				case (sel)
					urfm_pkg::SEL_TC:   r.flag_value = tc;
					urfm_pkg::SEL_LBD:  r.flag_value = lbd;
					urfm_pkg::SEL_RXNE: r.flag_value = rxne;
					default:            r.flag_value = 1'b0;
				endcase
			end
			urfm_pkg::OP_BREAK_REQ:  break_req = 1'b1;
			urfm_pkg::OP_LINE_BYTE: begin
				rx_byte = data;
				rxne = 1'b1;
			end
			urfm_pkg::OP_LINE_BREAK: lbd = 1'b1;
			default: begin
				// finish what is on the line, then start a break, then load data
				if (phase != urfm_pkg::PH_IDLE && !tc) begin
					tc = 1'b1;
					if (phase == urfm_pkg::PH_DATA) begin
						r.line_tx_valid = 1'b1;
						r.line_tx_byte = shift_byte;
					end else if (phase == urfm_pkg::PH_BREAK) begin
						r.line_tx_valid = 1'b1;
						r.line_tx_is_break = 1'b1;
					end
					phase = urfm_pkg::PH_IDLE;
				end
				if (break_req) begin
					break_req = 1'b0;
					tc = 1'b0;
					phase = urfm_pkg::PH_BREAK;
				end
				// a load in the same tick replaces a break just started
				if (!txe) begin
					shift_byte = tx_byte;
					tc = 1'b0;
					txe = 1'b1;
					phase = urfm_pkg::PH_DATA;
				end
				r.irq = (txe & ien.txe) | (lbd & ien.lbd) | (rxne & ien.rxne) | (tc & ien.tc);
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ien = '0;
			tx_byte = '0;
			shift_byte = '0;
			rx_byte = '0;
			txe = 1'b1;
			tc = 1'b0;
			rxne = 1'b0;
			lbd = 1'b0;
			break_req = 1'b0;
			phase = urfm_pkg::PH_IDLE;
			expected_q.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					urfm_pkg::CFG_TXE_IEN:  ien.txe = cfg_data;
					urfm_pkg::CFG_TC_IEN:   ien.tc = cfg_data;
					urfm_pkg::CFG_RXNE_IEN: ien.rxne = cfg_data;
					urfm_pkg::CFG_LBD_IEN:  ien.lbd = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transaction with no operation outstanding");
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("read_byte", want.read_byte, read_byte);
					check_field("flag_value", 8'(want.flag_value), 8'(flag_value));
					check_field("irq", 8'(want.irq), 8'(irq));
					check_field("line_tx_valid", 8'(want.line_tx_valid), 8'(line_tx_valid));
					check_field("line_tx_is_break", 8'(want.line_tx_is_break),
						8'(line_tx_is_break));
					check_field("line_tx_byte", want.line_tx_byte, line_tx_byte);
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_usart(urfm_pkg::op_t'(operation), data_byte,
					urfm_pkg::flag_sel_t'(flag_select)));
			outstanding = expected_q.size();
		end
	end

endmodule

@@ bench/uart_register_flag_model_tb.sv @@
// testbench top for the usart register and flag block: clock, reset, stimulus and verdict
// depends on urfm_pkg, uart_register_flag_model and urfm_flag_checker
`timescale 1ns / 1ps

module uart_register_flag_model_tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int N_PHASES = 6;
	localparam int ITEMS_TARGET = 800;
	localparam logic [urfm_pkg::CFG_INDEX_W-1:0] CFG_NO_REG = '1;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid, in_stall;
	logic [2:0]       operation;
	logic [7:0]       data_byte;
	logic [1:0]       flag_select;
	logic             out_valid, out_stall;
	logic [7:0]       read_byte;
	logic             flag_value, irq, line_tx_valid, line_tx_is_break;
	logic [7:0]       line_tx_byte;
	logic             cfg_write;
	logic [urfm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic             cfg_data;
	int               mismatches, outstanding;
	logic             no_idle = 1'b0;
	int               n_ops = 0, n_ticks = 0, n_settings = 0, idle_cycles = 0;

	always #2 clk = ~clk;

	uart_register_flag_model u_dut (.*);

	urfm_flag_checker u_checker (.*);

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic urfm_pkg::flag_sel_t any_sel();
		return urfm_pkg::flag_sel_t'(2'($urandom_range(0, 3)));
	endfunction

	// called at a rising edge, returns at the edge where the transaction is taken
	task automatic send_op(urfm_pkg::op_t op, logic [7:0] data, urfm_pkg::flag_sel_t sel);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= data;
		flag_select <= sel;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_ops++;
		if (op == urfm_pkg::OP_TICK) n_ticks++;
	endtask

	task automatic write_reg(logic [urfm_pkg::CFG_INDEX_W-1:0] idx, logic val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, then wait until every result has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_op(urfm_pkg::OP_TICK, any_byte(), any_sel());
	endtask

	// receiver side: random stall bursts between result transactions
	initial begin
		int stall_len;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall_len = draw_wait();
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		urfm_pkg::irq_en_t en;
		int quota;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= urfm_pkg::OP_WRITE_TX;
		data_byte <= '0;
		flag_select <= urfm_pkg::SEL_TC;
		cfg_write <= 1'b0;
		cfg_index <= urfm_pkg::CFG_TXE_IEN;
		cfg_data <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reads at reset, overwrite and overrun, break against a data load
		send_op(urfm_pkg::OP_READ_RX, 8'h00, urfm_pkg::SEL_TC);
		send_op(urfm_pkg::OP_READ_FLAG, 8'h00, urfm_pkg::SEL_TC);
		send_op(urfm_pkg::OP_READ_FLAG, 8'hff, urfm_pkg::SEL_LBD);
		send_op(urfm_pkg::OP_READ_FLAG, 8'h00, urfm_pkg::SEL_RXNE);
		send_op(urfm_pkg::OP_READ_FLAG, 8'hff, urfm_pkg::SEL_NONE);
		send_op(urfm_pkg::OP_CLEAR_FLAG, 8'h00, urfm_pkg::SEL_RXNE);
		send_op(urfm_pkg::OP_CLEAR_FLAG, 8'hff, urfm_pkg::SEL_NONE);
		send_op(urfm_pkg::OP_WRITE_TX, 8'h00, urfm_pkg::SEL_TC);
		send_op(urfm_pkg::OP_WRITE_TX, 8'hff, urfm_pkg::SEL_NONE);
		send_ticks(2);
		send_op(urfm_pkg::OP_READ_FLAG, 8'h00, urfm_pkg::SEL_TC);
		send_op(urfm_pkg::OP_LINE_BYTE, 8'hff, urfm_pkg::SEL_RXNE);
		send_op(urfm_pkg::OP_LINE_BYTE, 8'h5a, urfm_pkg::SEL_LBD);
		send_op(urfm_pkg::OP_READ_RX, 8'hff, urfm_pkg::SEL_NONE);
		send_op(urfm_pkg::OP_READ_RX, 8'h00, urfm_pkg::SEL_RXNE);
		send_op(urfm_pkg::OP_LINE_BREAK, 8'h00, urfm_pkg::SEL_LBD);
		send_op(urfm_pkg::OP_READ_FLAG, 8'h00, urfm_pkg::SEL_LBD);
		send_op(urfm_pkg::OP_CLEAR_FLAG, 8'h00, urfm_pkg::SEL_LBD);
		send_op(urfm_pkg::OP_CLEAR_FLAG, 8'h00, urfm_pkg::SEL_TC);
		send_op(urfm_pkg::OP_BREAK_REQ, 8'h00, urfm_pkg::SEL_TC);
		send_op(urfm_pkg::OP_WRITE_TX, 8'ha5, urfm_pkg::SEL_LBD);
		send_ticks(2);
		send_op(urfm_pkg::OP_BREAK_REQ, 8'hff, urfm_pkg::SEL_NONE);
		send_ticks(3);

		for (int p = 0; p < N_PHASES; p++) begin
			// enables change only with nothing in flight
			wait_drained();
			if (p == 0) en = '1;
			else if (p == 1) en = '0;
			else en = urfm_pkg::irq_en_t'(4'($urandom_range(0, 15)));
			write_reg(urfm_pkg::CFG_TXE_IEN, en.txe);
			write_reg(urfm_pkg::CFG_TC_IEN, en.tc);
			write_reg(urfm_pkg::CFG_RXNE_IEN, en.rxne);
			write_reg(urfm_pkg::CFG_LBD_IEN, en.lbd);
			if (p == 2) write_reg(CFG_NO_REG, 1'b1);
			n_settings++;
			no_idle = (p == 3 || p == 5);
			quota = (p + 1) * ITEMS_TARGET / N_PHASES;
			while (n_ops < quota) begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						send_op(urfm_pkg::OP_WRITE_TX, any_byte(), any_sel());
						if ($urandom_range(0, 3) == 0)
							send_op(urfm_pkg::OP_WRITE_TX, any_byte(), any_sel());
						send_ticks($urandom_range(1, 4));
						send_op(urfm_pkg::OP_READ_FLAG, any_byte(), urfm_pkg::SEL_TC);
						if ($urandom_range(0, 1))
							send_op(urfm_pkg::OP_CLEAR_FLAG, any_byte(), urfm_pkg::SEL_TC);
					end
					3, 4: begin
						send_op(urfm_pkg::OP_LINE_BYTE, any_byte(), any_sel());
						if ($urandom_range(0, 3) == 0)
							send_op(urfm_pkg::OP_LINE_BYTE, any_byte(), any_sel());
						send_op(urfm_pkg::OP_READ_FLAG, any_byte(), urfm_pkg::SEL_RXNE);
						send_op(urfm_pkg::OP_READ_RX, any_byte(), any_sel());
					end
					5: begin
						send_op(urfm_pkg::OP_BREAK_REQ, any_byte(), any_sel());
						if ($urandom_range(0, 1))
							send_op(urfm_pkg::OP_WRITE_TX, any_byte(), any_sel());
						send_ticks($urandom_range(1, 3));
						send_op(urfm_pkg::OP_READ_FLAG, any_byte(), urfm_pkg::SEL_TC);
					end
					6: begin
						send_op(urfm_pkg::OP_LINE_BREAK, any_byte(), any_sel());
						send_ticks(1);
						send_op(urfm_pkg::OP_READ_FLAG, any_byte(), urfm_pkg::SEL_LBD);
						send_op(urfm_pkg::OP_CLEAR_FLAG, any_byte(), any_sel());
					end
					default: begin
						repeat ($urandom_range(1, 4))
							send_op(urfm_pkg::op_t'(3'($urandom_range(0, 7))), any_byte(),
								any_sel());
					end
				endcase
			end
		end
		no_idle = 1'b0;

		wait_drained();
		$display("ran %0d operations, %0d of them ticks, under %0d interrupt enable settings",
			n_ops, n_ticks, n_settings);
		$display("random idling on both channels, with bursts free of idling");
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/urfm_pkg.sv
design/urfm_engine.sv
design/uart_register_flag_model.sv
bench/urfm_flag_checker.sv
bench/uart_register_flag_model_tb.sv
